// ===== design/assert_macros.svh =====
// Assertion macros shared by the pulse width capture modules.
// Included by file name from the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== design/pwc_pkg.sv =====
// Package for the pulse width capture block: widths, constants, register codes
// and the structs passed between lanes and the merge stage. No dependencies.
package pwc_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int MAX_CH       = 4;
	localparam int CH_W         = 2;
	localparam int CNT_W        = 16;
	localparam int OVF_W        = 6;
	localparam int SPEED_W      = 17;
	localparam int WIDTH_W      = OVF_W + CNT_W + 1;

	localparam logic [OVF_W-1:0] OVF_MAX     = 6'h3F;
	localparam logic [CNT_W-1:0] TIMEOUT_END = 16'hFFFF;
	localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd1800;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_SECOND_PAIR = 1'b0,
		REG_WIDTH_LIMIT = 1'b1
	} pwc_reg_t;

	// Input word actions
	typedef enum logic [0:0] {
		ACT_EVENT = 1'b0,
		ACT_READ  = 1'b1
	} pwc_act_t;

	// Per-lane view after the current word is applied
	typedef struct packed {
		logic                      done;
		logic                      falling;
		logic signed [SPEED_W-1:0] speed;
	} pwc_lane_stat_t;

	// One result word
	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic [MAX_CH-1:0]         falling_edge_bits;
		logic [MAX_CH-1:0]         done_bits;
	} pwc_result_t;

endpackage

// ===== design/pwc_in_if.sv =====
// Input channel of the pulse width capture block: valid/ready plus one event word.
// Depends on pwc_pkg for field widths.
interface pwc_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic                          update_flag;
	logic [pwc_pkg::MAX_CH-1:0]    capture_flags;
	logic [pwc_pkg::CNT_W-1:0]     capture_ch0;
	logic [pwc_pkg::CNT_W-1:0]     capture_ch1;
	logic [pwc_pkg::CNT_W-1:0]     capture_ch2;
	logic [pwc_pkg::CNT_W-1:0]     capture_ch3;
	logic [pwc_pkg::CH_W-1:0]      channel;

	modport source (
		output valid, action, update_flag, capture_flags,
		output capture_ch0, capture_ch1, capture_ch2, capture_ch3, channel,
		input  ready
	);
	modport sink (
		input  valid, action, update_flag, capture_flags,
		input  capture_ch0, capture_ch1, capture_ch2, capture_ch3, channel,
		output ready
	);
endinterface

// ===== design/pwc_out_if.sv =====
// Output channel of the pulse width capture block: valid/ready plus one result word.
// Depends on pwc_pkg for field widths.
interface pwc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [pwc_pkg::SPEED_W-1:0] speed;
	logic [pwc_pkg::MAX_CH-1:0]         falling_edge_bits;
	logic [pwc_pkg::MAX_CH-1:0]         done_bits;

	modport source (output valid, speed, falling_edge_bits, done_bits, input ready);
	modport sink   (input valid, speed, falling_edge_bits, done_bits, output ready);
endinterface

// ===== design/pwc_lane.sv =====
// One capture channel lane: holds the channel's measurement state and applies
// timer events and reads to it. Depends on pwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          timer_go,
	input  logic                          read_go,
	input  logic                          ovf,
	input  logic                          cap,
	input  logic [pwc_pkg::CNT_W-1:0]     val,
	input  logic [pwc_pkg::CNT_W-1:0]     limit,
	output pwc_pkg::pwc_lane_stat_t       stat
);

	logic                               done_q, started_q, falling_q;
	logic [pwc_pkg::OVF_W-1:0]          ovf_cnt_q;
	logic [pwc_pkg::CNT_W-1:0]          start_q, end_q;
	logic signed [pwc_pkg::SPEED_W-1:0] speed_q;

	logic                               done_d, started_d, falling_d;
	logic [pwc_pkg::OVF_W-1:0]          ovf_cnt_d;
	logic [pwc_pkg::CNT_W-1:0]          start_d, end_d;
	logic signed [pwc_pkg::SPEED_W-1:0] speed_d;

	logic signed [pwc_pkg::WIDTH_W-1:0] width;
	logic [pwc_pkg::WIDTH_W-1:0]        mag;

	// Pulse width from the held state: overflows * 2^16 + end - start
	always_comb begin
		width = $signed({1'b0, ovf_cnt_q, end_q}) -
			$signed({{(pwc_pkg::WIDTH_W-pwc_pkg::CNT_W){1'b0}}, start_q});
		mag   = width[pwc_pkg::WIDTH_W-1] ? pwc_pkg::WIDTH_W'(-width) : width;
	end

	// Next state for a timer event or a read
	always_comb begin
		done_d    = done_q;
		started_d = started_q;
		falling_d = falling_q;
		ovf_cnt_d = ovf_cnt_q;
		start_d   = start_q;
		end_d     = end_q;
		speed_d   = speed_q;
		if (timer_go && !done_q) begin
			// count overflows of an open pulse, time out at the top count
			if (ovf && started_q) begin
				if (ovf_cnt_q == pwc_pkg::OVF_MAX) begin
					done_d = 1'b1;
					end_d  = pwc_pkg::TIMEOUT_END;
				end else begin
					ovf_cnt_d = ovf_cnt_q + 1'b1;
				end
			end
			if (cap) begin
				if (started_q) begin
					done_d    = 1'b1;
					end_d     = val;
					falling_d = 1'b0;
				end else begin
					end_d     = '0;
					done_d    = 1'b0;
					ovf_cnt_d = '0;
					started_d = 1'b1;
					start_d   = val;
					falling_d = 1'b1;
				end
			end
		end else if (read_go && done_q) begin
			// take the width as speed when within the limit, then free the channel
			if (mag <= {{(pwc_pkg::WIDTH_W-pwc_pkg::CNT_W){1'b0}}, limit})
				speed_d = width[pwc_pkg::SPEED_W-1:0];
			done_d    = 1'b0;
			started_d = 1'b0;
			ovf_cnt_d = '0;
			start_d   = '0;
		end
	end

	// Hold channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			started_q <= 1'b0;
			falling_q <= 1'b0;
			ovf_cnt_q <= '0;
			start_q   <= '0;
			end_q     <= '0;
			speed_q   <= '0;
		end else begin
			done_q    <= done_d;
			started_q <= started_d;
			falling_q <= falling_d;
			ovf_cnt_q <= ovf_cnt_d;
			start_q   <= start_d;
			end_q     <= end_d;
			speed_q   <= speed_d;
		end
	end

	// Report the state as it stands after this word
	assign stat.done    = done_d;
	assign stat.falling = falling_d;
	assign stat.speed   = speed_d;

	`ASSERT_CLK(a_done_needs_start, clk, arst_n, done_q |-> started_q, "done without start")
	`ASSERT_CLK(a_idle_count_zero, clk, arst_n, !started_q |-> (ovf_cnt_q == '0),
		"overflow count on idle channel")
	`ASSERT_CLK(a_idle_start_zero, clk, arst_n, !started_q |-> (start_q == '0),
		"start time on idle channel")

endmodule

// ===== design/pwc_merge.sv =====
// Merge stage: combines the lane reports into one result word and buffers it
// in an output register plus a skid entry. Depends on pwc_pkg, pwc_out_if.
`include "assert_macros.svh"

module pwc_merge #(
	parameter int NUM_CHANNELS = pwc_pkg::NUM_CHANNELS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [pwc_pkg::CH_W-1:0]  sel,
	input  pwc_pkg::pwc_lane_stat_t   stats [pwc_pkg::MAX_CH],
	output logic                      ready,
	pwc_out_if.source                 out_ch
);

	pwc_pkg::pwc_result_t res;
	pwc_pkg::pwc_result_t data_s1, skid_q;
	logic                 valid_s1, skid_valid_q;
	logic                 pop;

	// Combine lanes: selected speed and the status bit vectors
	always_comb begin
		res = '0;
		for (int c = 0; c < pwc_pkg::MAX_CH; c++) begin
			res.falling_edge_bits[c] = stats[c].falling;
			res.done_bits[c]         = stats[c].done;
		end
		if ({1'b0, sel} < (pwc_pkg::CH_W+1)'(NUM_CHANNELS))
			res.speed = stats[sel].speed;
	end

	assign pop   = valid_s1 && out_ch.ready;
	assign ready = !skid_valid_q;

	// Output register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1     <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (!valid_s1) begin
				valid_s1 <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_s1 <= skid_valid_q ? skid_q : res;
		end else if (!valid_s1) begin
			data_s1 <= res;
		end
		if (!pop && valid_s1 && push)
			skid_q <= res;
	end

	assign out_ch.valid             = valid_s1;
	assign out_ch.speed             = data_s1.speed;
	assign out_ch.falling_edge_bits = data_s1.falling_edge_bits;
	assign out_ch.done_bits         = data_s1.done_bits;

	`ASSERT_CLK(a_skid_behind_out, clk, arst_n, skid_valid_q |-> valid_s1,
		"skid word without output word")
	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, push && skid_valid_q,
		"word pushed into full buffer")
	`ASSERT_CLK(a_stall_fills_skid, clk, arst_n, (push && valid_s1 && !out_ch.ready) |=> skid_valid_q,
		"stalled word not kept in skid entry")

endmodule

// ===== design/pulse_width_capture_core.sv =====
// Pulse width capture core: one word per clock on the input, one result word per
// input word, registered in the output register, or in the skid entry while that
// register waits. Each lane applies a word with no busy state, so the input takes a
// new word every cycle; a two-entry output buffer (output register plus skid entry)
// keeps input ready while one result waits; ready drops only once both are full.
// Configuration writes are applied at the clock edge where wr_en is high.
// Depends on pwc_pkg, pwc_in_if, pwc_out_if, pwc_lane and pwc_merge.
module pulse_width_capture_core #(
	parameter int NUM_CHANNELS = pwc_pkg::NUM_CHANNELS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [0:0]                wr_index,
	input  logic [pwc_pkg::CNT_W-1:0] wr_data,
	pwc_in_if.sink                    in_ch,
	pwc_out_if.source                 out_ch
);

	logic                      second_pair_q;
	logic [pwc_pkg::CNT_W-1:0] limit_q;
	logic                      accept;
	logic                      ready;
	logic [pwc_pkg::CNT_W-1:0] vals [pwc_pkg::MAX_CH];
	pwc_pkg::pwc_lane_stat_t   stats [pwc_pkg::MAX_CH];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_pair_q <= 1'b0;
			limit_q       <= pwc_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			unique case (pwc_pkg::pwc_reg_t'(wr_index))
				pwc_pkg::REG_SECOND_PAIR: second_pair_q <= wr_data[0];
				pwc_pkg::REG_WIDTH_LIMIT: limit_q       <= wr_data;
			endcase
		end
	end

	assign in_ch.ready = ready;
	assign accept      = in_ch.valid && ready;

	assign vals[0] = in_ch.capture_ch0;
	assign vals[1] = in_ch.capture_ch1;
	assign vals[2] = in_ch.capture_ch2;
	assign vals[3] = in_ch.capture_ch3;

	// Channel lanes; the second pair acts on timer events only when enabled
	for (genvar c = 0; c < pwc_pkg::MAX_CH; c++) begin : g_lane
		if (c < NUM_CHANNELS) begin : g_on
			pwc_lane u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.timer_go (accept && (in_ch.action == pwc_pkg::ACT_EVENT) &&
				           ((c < 2) || second_pair_q)),
				.read_go  (accept && (in_ch.action == pwc_pkg::ACT_READ) &&
				           (in_ch.channel == pwc_pkg::CH_W'(c))),
				.ovf      (in_ch.update_flag),
				.cap      (in_ch.capture_flags[c]),
				.val      (vals[c]),
				.limit    (limit_q),
				.stat     (stats[c])
			);
		end else begin : g_off
			assign stats[c] = '0;
		end
	end

	// Merge lane reports into the result word
	pwc_merge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.sel    (in_ch.channel),
		.stats  (stats),
		.ready  (ready),
		.out_ch (out_ch)
	);

endmodule
